@@ hdl/brca_pkg.sv @@
// ----------------------------------------------------------------------------
// brca_pkg
// Shared types and constants of the relation closure analyser: widths, the
// queue word carried from front to back, the result bundle and back states.
// ----------------------------------------------------------------------------
package brca_pkg;

  localparam int ROW_W       = 16;   // bits in one matrix row
  localparam int ROWNUM_W    = 4;    // width of a row number
  localparam int SIZE_W      = 5;    // width of the size register
  localparam int MAX_DIM_DEF = 16;
  localparam int QUEUE_DEF   = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [ROWNUM_W-1:0] idx;
    logic                last;
  } row_entry_t;

  typedef struct packed {
    logic       valid;
    row_entry_t entry;
  } queue_wr_t;

  typedef struct packed {
    logic       valid;
    row_entry_t entry;
  } queue_rd_t;

  typedef struct packed {
    logic                valid;
    logic [ROW_W-1:0]    closure_row;
    logic [ROWNUM_W-1:0] row_number;
    logic                is_reflexive;
    logic                is_symmetric;
    logic                is_transitive;
    logic                last_row;
  } result_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_CLOSE,
    BK_EMIT
  } back_state_e;

endpackage

@@ hdl/brca_queue.sv @@
// ----------------------------------------------------------------------------
// brca_queue
// Short first-in first-out queue of row words between the front and the back.
// ----------------------------------------------------------------------------
module brca_queue #(
  parameter int Depth = brca_pkg::QUEUE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brca_pkg::queue_wr_t wr_i,
  output logic                full_o,
  output brca_pkg::queue_rd_t rd_o,
  input  logic                pop_i
);
  import brca_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  row_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  push, pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign push   = wr_i.valid && !full_o;
  assign pop    = pop_i && (cnt_q != '0);

  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.entry = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_i.entry;
    end
  end

endmodule

@@ hdl/brca_front.sv @@
// ----------------------------------------------------------------------------
// brca_front
// Takes row words, holds the size register, masks stray columns and tags
// each row with its number and an end-of-matrix mark.
// ----------------------------------------------------------------------------
module brca_front #(
  parameter int MAX_DIM = brca_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [brca_pkg::ROW_W-1:0]    row_bits_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [brca_pkg::SIZE_W-1:0]   cfg_data_i,
  input  logic                          queue_full_i,
  output brca_pkg::queue_wr_t           wr_o
);
  import brca_pkg::*;

  localparam int DimCap = (MAX_DIM < ROW_W) ? MAX_DIM : ROW_W;

  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0] dim, idx, idx_next;
  logic [ROW_W-1:0]  mask;
  logic              accept, last;

  assign cfg_ready_o = 1'b1;
  assign busy        = queue_full_i;
  assign accept      = start && !busy;

  // size zero counts as one, large sizes saturate
  always_comb begin
    if (size_q == '0) begin
      dim = SIZE_W'(1);
    end else if (size_q > SIZE_W'(DimCap)) begin
      dim = SIZE_W'(DimCap);
    end else begin
      dim = size_q;
    end
  end

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      mask[c] = (SIZE_W'(c) < dim);
    end
  end

  assign idx      = (cnt_q >= dim) ? '0 : cnt_q;
  assign idx_next = idx + 1'b1;
  assign last     = (idx_next == dim);

  assign wr_o.valid       = accept;
  assign wr_o.entry.row   = row_bits_i & mask;
  assign wr_o.entry.idx   = idx[ROWNUM_W-1:0];
  assign wr_o.entry.last  = last;

  always_comb begin
    size_d = size_q;
    cnt_d  = cnt_q;
    if (cfg_valid_i) begin
      size_d = cfg_data_i;
      cnt_d  = '0;
    end else if (accept) begin
      cnt_d = last ? '0 : idx_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      cnt_q  <= '0;
    end else begin
      size_q <= size_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ hdl/brca_back.sv @@
// ----------------------------------------------------------------------------
// brca_back
// Holds the relation and closure rows, runs one Warshall pass per cycle
// while gathering the relation flags, then sends the closure rows out.
// ----------------------------------------------------------------------------
module brca_back #(
  parameter int MAX_DIM = brca_pkg::MAX_DIM_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brca_pkg::queue_rd_t rd_i,
  output logic                pop_o,
  output brca_pkg::result_t   res_o
);
  import brca_pkg::*;

  localparam int Depth = (MAX_DIM < ROW_W) ? MAX_DIM : ROW_W;
  localparam int IdxW  = $clog2(Depth);

  back_state_e       state_q, state_d;
  logic [IdxW-1:0]   k_q, e_q, lastidx_q;
  logic              refl_q, sym_q;

  logic [ROW_W-1:0]  rel_q [Depth];
  logic [ROW_W-1:0]  clo_q [Depth];
  logic [ROW_W-1:0]  sq_q  [Depth];

  logic [ROWNUM_W-1:0] kx;
  logic [ROW_W-1:0]    rel_k, clo_k, col_k;
  logic [Depth-1:0]    active;
  logic                trans_bad, load_last;

  assign kx        = ROWNUM_W'(k_q);
  assign rel_k     = rel_q[k_q];
  assign clo_k     = clo_q[k_q];
  assign load_last = pop_o && rd_i.entry.last;

  // lanes past the matrix end may hold rows of an earlier, larger matrix
  always_comb begin
    col_k     = '0;
    trans_bad = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      active[i] = (IdxW'(i) <= lastidx_q);
      col_k[i]  = active[i] && rel_q[i][kx];
      trans_bad = trans_bad | (active[i] && ((sq_q[i] & ~rel_q[i]) != '0));
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_LOAD: begin
        if (rd_i.valid && rd_i.entry.last) state_d = BK_CLOSE;
      end
      BK_CLOSE: begin
        if (k_q == lastidx_q) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (e_q == lastidx_q) state_d = BK_LOAD;
      end
      default: state_d = BK_LOAD;
    endcase
  end

  always_comb begin
    pop_o              = (state_q == BK_LOAD) && rd_i.valid;
    res_o.valid        = (state_q == BK_EMIT);
    res_o.closure_row  = clo_q[e_q];
    res_o.row_number   = ROWNUM_W'(e_q);
    res_o.is_reflexive = refl_q;
    res_o.is_symmetric = sym_q;
    res_o.is_transitive = !trans_bad;
    res_o.last_row     = (e_q == lastidx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_LOAD;
      k_q       <= '0;
      e_q       <= '0;
      lastidx_q <= '0;
      refl_q    <= 1'b1;
      sym_q     <= 1'b1;
    end else begin
      state_q <= state_d;
      if (load_last) begin
        k_q       <= '0;
        e_q       <= '0;
        lastidx_q <= rd_i.entry.idx[IdxW-1:0];
        refl_q    <= 1'b1;
        sym_q     <= 1'b1;
      end else if (state_q == BK_CLOSE) begin
        k_q    <= k_q + 1'b1;
        refl_q <= refl_q & rel_k[kx];
        sym_q  <= sym_q & (rel_k == col_k);
      end else if (state_q == BK_EMIT) begin
        e_q <= e_q + 1'b1;
      end
    end
  end

  // row k is unchanged by its own pass, so all lanes update together
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rel_q[rd_i.entry.idx[IdxW-1:0]] <= rd_i.entry.row;
      clo_q[rd_i.entry.idx[IdxW-1:0]] <= rd_i.entry.row;
    end
    if (load_last) begin
      for (int i = 0; i < Depth; i++) begin
        sq_q[i] <= '0;
      end
    end
    if (state_q == BK_CLOSE) begin
      for (int i = 0; i < Depth; i++) begin
        if (clo_q[i][kx]) clo_q[i] <= clo_q[i] | clo_k;
        if (rel_q[i][kx]) sq_q[i] <= sq_q[i] | rel_k;
      end
    end
  end

endmodule

@@ hdl/binary_relation_closure_analyzer.sv @@
// ----------------------------------------------------------------------------
// binary_relation_closure_analyzer
// Transitive closure of a square 0/1 relation with reflexive, symmetric and
// transitive flags.
// ----------------------------------------------------------------------------
// Usage:
//   A matrix of N rows (N from the size register, 1 to 16) is sent one row
//   word per cycle: a word is taken at a clock edge with start high and busy
//   low. Column bits at or above N are dropped.
//   A four-word queue parts the loader from the closure engine, so rows keep
//   flowing while the engine works until the queue fills and busy rises.
//   After the last row has passed through the queue to the engine it runs
//   N passes, one per cycle, then drives N results on consecutive cycles,
//   each marked by result_valid_o for one cycle. The engine takes a matrix
//   as N row loads, then N passes, then N results. The receiver cannot
//   hold results off.
//   The size register is written over the cfg channel, always ready; a
//   write restarts loading at row 0. Write it only while idle.
//   Reset sets the size to 4, empties the queue and restarts at row 0.
// ----------------------------------------------------------------------------
module binary_relation_closure_analyzer #(
  parameter int MAX_DIM     = brca_pkg::MAX_DIM_DEF,
  parameter int QUEUE_DEPTH = brca_pkg::QUEUE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [brca_pkg::ROW_W-1:0]       row_bits_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [brca_pkg::SIZE_W-1:0]      cfg_data_i,
  output logic                             result_valid_o,
  output logic [brca_pkg::ROW_W-1:0]       closure_row_o,
  output logic [brca_pkg::ROWNUM_W-1:0]    row_number_o,
  output logic                             is_reflexive_o,
  output logic                             is_symmetric_o,
  output logic                             is_transitive_o,
  output logic                             last_row_o
);
  import brca_pkg::*;

  queue_wr_t wr;
  queue_rd_t rd;
  result_t   res;
  logic      full, pop;

  brca_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .row_bits_i   (row_bits_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (full),
    .wr_o         (wr)
  );

  brca_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .full_o (full),
    .rd_o   (rd),
    .pop_i  (pop)
  );

  brca_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd),
    .pop_o  (pop),
    .res_o  (res)
  );

  assign result_valid_o  = res.valid;
  assign closure_row_o   = res.closure_row;
  assign row_number_o    = res.row_number;
  assign is_reflexive_o  = res.is_reflexive;
  assign is_symmetric_o  = res.is_symmetric;
  assign is_transitive_o = res.is_transitive;
  assign last_row_o      = res.last_row;

endmodule
